// ----- rtl/core/pbm_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, defaults, register indexes and inter-module structs for the
// per-pixel bitwise median block. No dependencies.
package pbm_pkg;

  localparam int PIXELS_DEF     = 2048;
  localparam int MAX_FRAMES_DEF = 1024;

  localparam int PIX_W   = 8;
  localparam int POS_W   = 11;
  localparam int FRM_W   = 10;
  localparam int BIT_W   = 3;
  localparam int CNT_W   = 11;
  localparam int FCFG_W  = 11;
  localparam int PCFG_W  = 12;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;

  localparam logic [FCFG_W-1:0] FRAMES_RST = FCFG_W'(500);
  localparam logic [PCFG_W-1:0] PIXELS_RST = PCFG_W'(2000);
  localparam logic [PIX_W-1:0]  GUESS_INIT = PIX_W'(128);
  localparam logic [CNT_W-1:0]  CNT_MAX    = '1;
  localparam logic [BIT_W-1:0]  BIT_TOP    = BIT_W'(7);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PIXELS = CFG_IDX_W'(1);

  // One accepted pixel on its way to the read-modify-write stage.
  typedef struct packed {
    logic              valid;
    logic [PIX_W-1:0]  pix;
    logic [POS_W-1:0]  pos;
    logic              last_pos;
    logic              last_frame;
    logic [BIT_W-1:0]  bit_idx;
    logic [CNT_W-1:0]  thr;
  } pbm_issue_t;

  // Back-pressure and clearing status from the store.
  typedef struct packed {
    logic busy;
    logic take;
  } pbm_stat_t;

endpackage

// ----- rtl/core/pbm_if.sv -----
`timescale 1ns / 1ps
// Valid/ready stream interfaces for pixel requests and median results.
// Depends on pbm_pkg.
interface pbm_in_if;
  import pbm_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface pbm_out_if;
  import pbm_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] median_value;
  logic [POS_W-1:0] pixel_index;
  logic             last_pixel;
  modport source (output valid, output median_value, output pixel_index,
                  output last_pixel, input ready);
  modport sink   (input valid, input median_value, input pixel_index,
                  input last_pixel, output ready);
endinterface

// ----- rtl/core/pbm_seq.sv -----
`timescale 1ns / 1ps
// Configuration registers and the position / frame / bit sequencer that
// tags each accepted pixel. Depends on pbm_pkg and pbm_if.
module pbm_seq #(
  parameter int PIXELS     = pbm_pkg::PIXELS_DEF,
  parameter int MAX_FRAMES = pbm_pkg::MAX_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  pbm_in_if.sink                        in_if,
  input  logic                          cfg_we,
  input  logic [pbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pbm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  pbm_pkg::pbm_stat_t            stat,
  output pbm_pkg::pbm_issue_t           iss
);
  import pbm_pkg::*;

  logic [FCFG_W-1:0] frames_cfg_r;
  logic [PCFG_W-1:0] pixels_cfg_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [FRM_W-1:0]  frame_r, frame_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [FCFG_W-1:0] frames_eff;
  logic [PCFG_W-1:0] pixels_eff;
  logic              last_pos, last_frame, accept;

  always_comb begin
    if (frames_cfg_r == '0) begin
      frames_eff = FCFG_W'(1);
    end else if (32'(frames_cfg_r) > MAX_FRAMES) begin
      frames_eff = FCFG_W'(MAX_FRAMES);
    end else begin
      frames_eff = frames_cfg_r;
    end
    if (pixels_cfg_r == '0) begin
      pixels_eff = PCFG_W'(1);
    end else if (32'(pixels_cfg_r) > PIXELS) begin
      pixels_eff = PCFG_W'(PIXELS);
    end else begin
      pixels_eff = pixels_cfg_r;
    end
  end

  assign last_pos   = (PCFG_W'(pos_r) + PCFG_W'(1)) >= pixels_eff;
  assign last_frame = (FCFG_W'(frame_r) + FCFG_W'(1)) >= frames_eff;
  assign in_if.ready = stat.take;
  assign accept      = in_if.valid & stat.take;

  always_comb begin
    iss.valid      = accept;
    iss.pix        = in_if.pixel_value;
    iss.pos        = pos_r;
    iss.last_pos   = last_pos;
    iss.last_frame = last_frame;
    iss.bit_idx    = bit_r;
    iss.thr        = CNT_W'({1'b0, frames_eff[FCFG_W-1:1]}) + CNT_W'(1);
  end

  // Advance the scan: position, then frame, then the bit under test.
  always_comb begin
    pos_nxt   = pos_r;
    frame_nxt = frame_r;
    bit_nxt   = bit_r;
    if (accept) begin
      if (last_pos) begin
        pos_nxt = '0;
        if (last_frame) begin
          frame_nxt = '0;
          bit_nxt   = (bit_r == '0) ? BIT_TOP : bit_r - BIT_W'(1);
        end else begin
          frame_nxt = frame_r + FRM_W'(1);
        end
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_cfg_r <= FRAMES_RST;
      pixels_cfg_r <= PIXELS_RST;
      pos_r        <= '0;
      frame_r      <= '0;
      bit_r        <= BIT_TOP;
    end else begin
      pos_r   <= pos_nxt;
      frame_r <= frame_nxt;
      bit_r   <= bit_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAMES: frames_cfg_r <= cfg_wdata[FCFG_W-1:0];
          CFG_PIXELS: pixels_cfg_r <= cfg_wdata[PCFG_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- rtl/core/pbm_rmw.sv -----
`timescale 1ns / 1ps
// Guess/count memory with clearing pass, read-modify-write stage with
// same-entry forwarding, and the result register. Depends on pbm_pkg, pbm_if.
module pbm_rmw #(
  parameter int PIXELS = pbm_pkg::PIXELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pbm_pkg::pbm_issue_t iss,
  output pbm_pkg::pbm_stat_t  stat,
  pbm_out_if.source           out_if
);
  import pbm_pkg::*;

  localparam int AW    = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int ENT_W = PIX_W + CNT_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(PIXELS - 1);

  logic [ENT_W-1:0] mem [PIXELS];
  logic [ENT_W-1:0] rd_q_r;

  logic             clr_active_r;
  logic [AW-1:0]    clr_addr_r;

  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [POS_W-1:0] s1_pos_r;
  logic             s1_last_pos_r, s1_last_frame_r;
  logic [BIT_W-1:0] s1_bit_r;
  logic [CNT_W-1:0] s1_thr_r;
  logic             s1_fwd_r;
  logic [ENT_W-1:0] s1_fwd_data_r;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_median_r;
  logic [POS_W-1:0] out_index_r;
  logic             out_last_r;

  logic [AW-1:0]    rd_addr, s1_addr, wr_addr;
  logic [ENT_W-1:0] cur, upd, wr_data;
  logic [PIX_W-1:0] g_cur, g_new, g_bit;
  logic [CNT_W-1:0] c_cur, c_inc;
  logic             s1_emit, s1_go, s1_fire, wr_en;

  assign rd_addr = AW'(iss.pos);
  assign s1_addr = AW'(s1_pos_r);

  assign cur   = s1_fwd_r ? s1_fwd_data_r : rd_q_r;
  assign g_cur = cur[ENT_W-1:CNT_W];
  assign c_cur = cur[CNT_W-1:0];

  assign s1_emit = s1_last_frame_r & (s1_bit_r == '0);
  assign s1_go   = ~s1_emit | ~out_valid_r | out_if.ready;
  assign s1_fire = s1_valid_r & s1_go;

  assign stat.busy = clr_active_r;
  assign stat.take = ~clr_active_r & (~s1_valid_r | s1_go);

  // Count, then refine the guess on the last frame of the pass; reset it on emit.
  always_comb begin
    c_inc = c_cur;
    if (s1_pix_r >= g_cur && c_cur != CNT_MAX) begin
      c_inc = c_cur + CNT_W'(1);
    end
    g_bit = PIX_W'(1) << s1_bit_r;
    g_new = g_cur;
    if (c_inc < s1_thr_r) begin
      g_new = g_new & ~g_bit;
    end
    if (s1_bit_r != '0) begin
      g_new = g_new | (g_bit >> 1);
    end
    if (!s1_last_frame_r) begin
      upd = {g_cur, c_inc};
    end else if (s1_emit) begin
      upd = {GUESS_INIT, CNT_W'(0)};
    end else begin
      upd = {g_new, CNT_W'(0)};
    end
  end

  always_comb begin
    if (clr_active_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = {GUESS_INIT, CNT_W'(0)};
    end else begin
      wr_en   = s1_fire;
      wr_addr = s1_addr;
      wr_data = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (iss.valid) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Stage payload; forward the write when the next pixel hits the same entry.
  always_ff @(posedge clk) begin
    if (iss.valid) begin
      s1_pix_r        <= iss.pix;
      s1_pos_r        <= iss.pos;
      s1_last_pos_r   <= iss.last_pos;
      s1_last_frame_r <= iss.last_frame;
      s1_bit_r        <= iss.bit_idx;
      s1_thr_r        <= iss.thr;
      s1_fwd_r        <= s1_fire && (s1_addr == rd_addr);
      s1_fwd_data_r   <= upd;
    end
    if (s1_fire && s1_emit) begin
      out_median_r <= g_new;
      out_index_r  <= s1_pos_r;
      out_last_r   <= s1_last_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_ADDR) begin
          clr_active_r <= 1'b0;
        end
      end
      if (iss.valid) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire && s1_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.median_value = out_median_r;
  assign out_if.pixel_index  = out_index_r;
  assign out_if.last_pixel   = out_last_r;

endmodule

// ----- rtl/core/per_pixel_bitwise_median.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Payload                                   Handshake
// in_if    in   pixel_value[7:0]                          valid/ready
// out_if   out  median_value[7:0] pixel_index[10:0] last  valid/ready
// cfg_     in   cfg_index[1:0] cfg_wdata[11:0]            cfg_we, no wait
//
// One pixel per cycle: a memory read on acceptance fills the stage-1 registers,
// then the read-modify-write and the result register load fire together, so a
// result passes the stage-1 registers and the result register before it is valid.
// The single-port write of the guess/count memory sets the one-per-cycle rate.
// After reset a clearing pass writes every entry with ready low. After that,
// input stalls only when an emitting pixel waits on a full result register.
module per_pixel_bitwise_median #(
  parameter int PIXELS     = pbm_pkg::PIXELS_DEF,
  parameter int MAX_FRAMES = pbm_pkg::MAX_FRAMES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pbm_in_if.sink                         in_if,
  pbm_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [pbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pbm_pkg::*;

  pbm_issue_t iss;
  pbm_stat_t  stat;

  pbm_seq #(
    .PIXELS     (PIXELS),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .iss       (iss)
  );

  pbm_rmw #(
    .PIXELS (PIXELS)
  ) u_rmw (
    .clk    (clk),
    .rst_n  (rst_n),
    .iss    (iss),
    .stat   (stat),
    .out_if (out_if)
  );

`ifndef SYNTH
  // No request may reach the store while the clearing pass runs.
  a_no_issue_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> !iss.valid)
    else $error("pixel issued during clearing pass");

  // Only the last frame of the final pass can raise a result.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (iss.valid && (!iss.last_frame || iss.bit_idx != '0)) |-> ##2 !$rose(out_if.valid))
    else $error("result raised by a pixel outside the final pass");
`endif

endmodule

// ----- tb/tb_per_pixel_bitwise_median.sv -----
`timescale 1ns / 1ps
// Self-checking bench for per_pixel_bitwise_median: a directed table, then random
// stacks in several frame/pixel settings, checked against the table or a predictor.
// Depends on pbm_pkg, pbm_in_if/pbm_out_if and the per_pixel_bitwise_median RTL.
module tb_per_pixel_bitwise_median;
  import pbm_pkg::*;

  localparam int CFG_GUARD       = 6;
  localparam int DRAIN_CYCLES    = 20;
  localparam int STALL_LIMIT     = 4 * PIXELS_DEF + 1000;
  localparam int ITEM_TARGET     = 1750;
  localparam int GAP_STAGE_ITEMS = 600;
  localparam int SLOW_GAP_PCT    = 79;
  localparam int FAST_GAP_PCT    = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

  typedef struct packed {
    logic [PIX_W-1:0] median_value;
    logic [POS_W-1:0] pixel_index;
    logic             last_pixel;
  } median_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             typed;
    median_t          exp;
  } pixel_row_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] frames;
    logic [CFG_DATA_W-1:0] pixels;
    logic [9:0]            count;
  } setting_t;

  // One frame of one pixel: each request is a whole pass, so eight make a median.
  localparam pixel_row_t DIRECTED [24] = '{
    '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b1, '{8'hFF, 11'd0, 1'b1}},
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{8'h00, 11'd0, 1'b1}},
    '{8'h80, 1'b0, '0}, '{8'h7F, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'hFE, 1'b0, '0},
    '{8'h55, 1'b0, '0}, '{8'hAA, 1'b0, '0}, '{8'h0F, 1'b0, '0}, '{8'hF0, 1'b0, '0}
  };

  // Saturating, oversized and minimal settings, most run only part way before switching.
  localparam setting_t EDGE_SETTINGS [6] = '{
    '{12'd1024, 12'd1,    10'd60},
    '{12'd4095, 12'd3,    10'd60},
    '{12'd1,    12'd2048, 10'd80},
    '{12'd2,    12'd4095, 10'd60},
    '{12'd1025, 12'd2049, 10'd40},
    '{12'd1,    12'd1,    10'd64}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pbm_in_if  pix_if ();
  pbm_out_if med_if ();

  per_pixel_bitwise_median i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (pix_if),
    .out_if    (med_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state
  logic [PIX_W-1:0]  guess_mem [PIXELS_DEF];
  logic [CNT_W-1:0]  tally_mem [PIXELS_DEF];
  logic [POS_W-1:0]  scan_pos;
  logic [FRM_W-1:0]  scan_frame;
  logic [BIT_W-1:0]  scan_bit;
  logic [FCFG_W-1:0] frames_cfg;
  logic [PCFG_W-1:0] pixels_cfg;

  median_t median_q [$];
  median_t typed_res;
  logic    typed_valid;
  int      items_sent;
  int      mismatch_count;
  int      quiet_cycles;
  int      in_gap_pct;
  int      out_gap_pct;

  function automatic int unsigned clamp_count(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the search by one pixel; returns 1 when a median falls out.
  function automatic bit predict_pixel(input logic [PIX_W-1:0] pix, output median_t res);
    int unsigned      frames;
    int unsigned      pixels;
    int unsigned      slot;
    int unsigned      bitn;
    bit               last_pos;
    bit               last_frame;
    bit               emit;
    logic [PIX_W-1:0] g;
    frames     = clamp_count(frames_cfg, MAX_FRAMES_DEF);
    pixels     = clamp_count(pixels_cfg, PIXELS_DEF);
    slot       = scan_pos % PIXELS_DEF;
    bitn       = scan_bit;
    last_pos   = (32'(scan_pos) + 1) >= pixels;
    last_frame = (32'(scan_frame) + 1) >= frames;
    emit       = 1'b0;
    res        = '0;
    if (pix >= guess_mem[slot] && tally_mem[slot] != CNT_MAX)
      tally_mem[slot] = tally_mem[slot] + 1'b1;
    if (last_frame) begin
      g = guess_mem[slot];
      if (32'(tally_mem[slot]) < frames / 2 + 1) g[bitn] = 1'b0;
      if (bitn > 0) g[bitn-1] = 1'b1;
      tally_mem[slot] = '0;
      if (bitn == 0) begin
        res  = '{g, scan_pos, last_pos};
        emit = 1'b1;
        g    = GUESS_INIT;
      end
      guess_mem[slot] = g;
    end
    if (last_pos) begin
      scan_pos = '0;
      if (last_frame) begin
        scan_frame = '0;
        scan_bit   = (bitn == 0) ? BIT_TOP : BIT_W'(bitn - 1);
      end else begin
        scan_frame = scan_frame + 1'b1;
      end
    end else begin
      scan_pos = scan_pos + 1'b1;
    end
    return emit;
  endfunction

  always @(negedge clk) begin
    med_if.ready <= ($urandom_range(99) >= out_gap_pct);
  end

  // Score results, track register writes and predict each accepted request.
  always @(posedge clk) begin
    median_t got;
    median_t want;
    median_t res;
    bit      active;
    if (!rst_n) begin
      for (int i = 0; i < PIXELS_DEF; i++) begin
        guess_mem[i] = GUESS_INIT;
        tally_mem[i] = '0;
      end
      scan_pos     = '0;
      scan_frame   = '0;
      scan_bit     = BIT_TOP;
      frames_cfg   = FRAMES_RST;
      pixels_cfg   = PIXELS_RST;
      quiet_cycles = 0;
    end else begin
      active = 1'b0;
      if (med_if.valid && med_if.ready) begin
        active = 1'b1;
        got = '{med_if.median_value, med_if.pixel_index, med_if.last_pixel};
        if (median_q.size() == 0) begin
          $error("unexpected result: median_value %0d pixel_index %0d last_pixel %0d",
                 got.median_value, got.pixel_index, got.last_pixel);
          mismatch_count++;
        end else begin
          want = median_q.pop_front();
          if (got.median_value != want.median_value) begin
            $error("median_value: expected %0d, got %0d", want.median_value, got.median_value);
            mismatch_count++;
          end
          if (got.pixel_index != want.pixel_index) begin
            $error("pixel_index: expected %0d, got %0d", want.pixel_index, got.pixel_index);
            mismatch_count++;
          end
          if (got.last_pixel != want.last_pixel) begin
            $error("last_pixel: expected %0d, got %0d", want.last_pixel, got.last_pixel);
            mismatch_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAMES: frames_cfg = cfg_wdata[FCFG_W-1:0];
          CFG_PIXELS: pixels_cfg = cfg_wdata[PCFG_W-1:0];
          default: ;
        endcase
      end
      if (pix_if.valid && pix_if.ready) begin
        active = 1'b1;
        if (predict_pixel(pix_if.pixel_value, res) && !typed_valid) median_q.push_back(res);
        if (typed_valid) median_q.push_back(typed_res);
      end
      quiet_cycles = active ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_per_pixel_bitwise_median failed");
        $finish;
      end
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] v);
    if (items_sent < GAP_STAGE_ITEMS) begin
      in_gap_pct  = FAST_GAP_PCT;
      out_gap_pct = SLOW_GAP_PCT;
    end else if (items_sent < 2 * GAP_STAGE_ITEMS) begin
      in_gap_pct  = SLOW_GAP_PCT;
      out_gap_pct = FAST_GAP_PCT;
    end else begin
      in_gap_pct  = 0;
      out_gap_pct = 0;
    end
    while ($urandom_range(99) < in_gap_pct) begin
      pix_if.valid <= 1'b0;
      @(negedge clk);
    end
    pix_if.valid       <= 1'b1;
    pix_if.pixel_value <= v;
    do @(posedge clk); while (!(pix_if.valid && pix_if.ready));
    items_sent++;
    @(negedge clk);
  endtask

  // Drain every pending median, then give the pipeline time to empty.
  task automatic settle();
    pix_if.valid <= 1'b0;
    while (median_q.size() != 0) @(negedge clk);
    repeat (CFG_GUARD) @(negedge clk);
  endtask

  task automatic program_stack(input logic [CFG_DATA_W-1:0] frames,
                               input logic [CFG_DATA_W-1:0] pixels);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAMES;
    cfg_wdata <= frames;
    @(negedge clk);
    cfg_index <= CFG_PIXELS;
    cfg_wdata <= pixels;
    @(negedge clk);
    // Writes past the register list must leave the settings alone.
    if ($urandom_range(3) == 0) begin
      cfg_index <= $urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3;
      cfg_wdata <= CFG_DATA_W'($urandom);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned frames;
    int unsigned pixels;
    int unsigned count;
    logic [PIX_W-1:0] pix;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    pix_if.valid       = 1'b0;
    pix_if.pixel_value = '0;
    med_if.ready       = 1'b0;
    typed_valid        = 1'b0;
    typed_res          = '0;
    items_sent         = 0;
    mismatch_count     = 0;
    quiet_cycles       = 0;
    in_gap_pct         = FAST_GAP_PCT;
    out_gap_pct        = SLOW_GAP_PCT;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero in both registers acts as one frame of one pixel.
    program_stack('0, '0);
    foreach (DIRECTED[i]) begin
      typed_valid = DIRECTED[i].typed;
      typed_res   = DIRECTED[i].exp;
      send_pixel(DIRECTED[i].pix);
    end
    typed_valid = 1'b0;

    foreach (EDGE_SETTINGS[i]) begin
      settle();
      program_stack(EDGE_SETTINGS[i].frames, EDGE_SETTINGS[i].pixels);
      for (int n = 0; n < EDGE_SETTINGS[i].count; n++) send_pixel(PIX_W'($urandom));
    end

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(7) == 0) begin
        frames = $urandom_range(1) ? $urandom_range(5, 4095) : $urandom_range(0, 2);
        pixels = $urandom_range(1) ? $urandom_range(9, 4095) : $urandom_range(0, 2);
        count  = $urandom_range(20, 80);
      end else begin
        frames = $urandom_range(0, 4);
        pixels = $urandom_range(0, 6);
        // Whole runs mostly, sometimes ragged so the next setting lands mid-pass.
        count  = 8 * clamp_count(frames, 4) * clamp_count(pixels, 6) * $urandom_range(1, 2);
        if ($urandom_range(3) == 0) count += $urandom_range(1, 7);
      end
      settle();
      program_stack(CFG_DATA_W'(frames), CFG_DATA_W'(pixels));
      for (int n = 0; n < count; n++) begin
        case ($urandom_range(9))
          0:       pix = '0;
          1:       pix = '1;
          2, 3:    pix = PIX_W'($urandom_range(120, 136));
          default: pix = PIX_W'($urandom);
        endcase
        send_pixel(pix);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tb_per_pixel_bitwise_median passed");
    end else begin
      $display("tb_per_pixel_bitwise_median failed");
    end
    $finish;
  end

endmodule

// ----- per_pixel_bitwise_median.f -----
rtl/core/pbm_pkg.sv
rtl/core/pbm_if.sv
rtl/core/pbm_seq.sv
rtl/core/pbm_rmw.sv
rtl/core/per_pixel_bitwise_median.sv
tb/tb_per_pixel_bitwise_median.sv
